@@ rtl/assert_macros.svh @@
// Assertion macros used by the top level of the point transform block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an antecedent is followed by a consequent, delayed by dly.
`define ASSERT_DELAYED(label, clk, rst, ante, cons, dly) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(dly) (cons)) \
    else $error("delayed check failed");

// Checks that a condition implies another one in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

`endif

@@ rtl/ptpd_pkg.sv @@
// Package with types, constants and helpers of the point transform block.
package ptpd_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DATA_W        = 32;
  localparam int REG_W         = 64;
  localparam int NUM_REGS      = 8;
  localparam int ADDR_W        = 6;
  localparam int ACC_W         = 66;
  localparam int QB            = 33;
  localparam int REM_W         = ACC_W + QB;
  localparam int PIPE_LAT      = QB + 6;

  localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

  typedef logic [NUM_REGS-1:0][REG_W-1:0] matrix_t;

  localparam matrix_t MAT_RESET = {
    64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000, 64'h0,
    64'h0, 64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000
  };

  typedef struct packed {
    logic signed [DATA_W-1:0] point_x;
    logic signed [DATA_W-1:0] point_y;
    logic signed [DATA_W-1:0] point_z;
  } point_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] out_x;
    logic signed [DATA_W-1:0] out_y;
    logic signed [DATA_W-1:0] out_z;
    logic                     divide_fault;
  } result_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              fault;
  } lane_out_t;

  typedef struct packed {
    logic nneg;
    logic dneg;
    logic nzero;
    logic dzero;
    logic ovf;
  } div_flags_t;

  function automatic logic signed [DATA_W-1:0] elem(matrix_t m, int r, int c);
    logic [2:0] idx;
    idx = 3'(r * 2 + (c >> 1));
    return (c & 1) != 0 ? m[idx][REG_W-1:DATA_W] : m[idx][DATA_W-1:0];
  endfunction

endpackage

@@ rtl/ptpd_cfg_regs.sv @@
// Matrix register file behind the APB configuration port.
module ptpd_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ptpd_pkg::ADDR_W-1:0]   paddr,
  input  logic [ptpd_pkg::REG_W-1:0]    pwdata,
  output logic [ptpd_pkg::REG_W-1:0]    prdata,
  output ptpd_pkg::matrix_t             mat
);

  always_ff @(posedge clk) begin
    if (rst) begin
      mat <= ptpd_pkg::MAT_RESET;
    end else if (psel && penable && pwrite) begin
      mat[paddr[ptpd_pkg::ADDR_W-1:3]] <= pwdata;
    end
  end

  assign prdata = mat[paddr[ptpd_pkg::ADDR_W-1:3]];

endmodule

@@ rtl/ptpd_mac.sv @@
// Two-stage multiply and accumulate of the point against the four matrix columns.
module ptpd_mac #(
  parameter int FRAC_BITS = ptpd_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  ptpd_pkg::point_t                     pt,
  input  ptpd_pkg::matrix_t                    mat,
  output logic [3:0][ptpd_pkg::ACC_W-1:0]      acc
);

  logic signed [ptpd_pkg::DATA_W-1:0]   pv [3];
  logic signed [2*ptpd_pkg::DATA_W-1:0] prod [4][3];

  assign pv[0] = pt.point_x;
  assign pv[1] = pt.point_y;
  assign pv[2] = pt.point_z;

  always_ff @(posedge clk) begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 3; r++) begin
        prod[c][r] <= pv[r] * ptpd_pkg::elem(mat, r, c);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 4; c++) begin
      acc[c] <= ptpd_pkg::ACC_W'(prod[c][0]) + ptpd_pkg::ACC_W'(prod[c][1])
              + ptpd_pkg::ACC_W'(prod[c][2])
              + (ptpd_pkg::ACC_W'(ptpd_pkg::elem(mat, 3, c)) <<< FRAC_BITS);
    end
  end

endmodule

@@ rtl/ptpd_div_lane.sv @@
// Pipelined signed divide with saturation for one coordinate, one quotient bit per stage.
module ptpd_div_lane #(
  parameter int FRAC_BITS = ptpd_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic signed [ptpd_pkg::ACC_W-1:0]  num,
  input  logic signed [ptpd_pkg::ACC_W-1:0]  den,
  output ptpd_pkg::lane_out_t                res
);

  localparam int AW = ptpd_pkg::ACC_W;
  localparam int RW = ptpd_pkg::REM_W;
  localparam int QW = ptpd_pkg::QB;

  ptpd_pkg::div_flags_t a_flags;
  logic [AW-1:0]        a_nm;
  logic [AW-1:0]        a_dm;

  ptpd_pkg::div_flags_t b_flags;
  ptpd_pkg::div_flags_t b_flags_next;
  logic [RW-1:0]        b_rem;
  logic [AW-1:0]        b_dm;

  ptpd_pkg::div_flags_t s_flags [QW];
  logic [RW-1:0]        s_rem   [QW];
  logic [AW-1:0]        s_dm    [QW];
  logic [QW-1:0]        s_q     [QW];

  always_ff @(posedge clk) begin
    a_flags.nneg  <= num[AW-1];
    a_flags.dneg  <= den[AW-1];
    a_flags.nzero <= (num == '0);
    a_flags.dzero <= (den == '0);
    a_flags.ovf   <= 1'b0;
    a_nm          <= num[AW-1] ? AW'(-num) : AW'(num);
    a_dm          <= den[AW-1] ? AW'(-den) : AW'(den);
  end

  always_comb begin
    b_flags_next     = a_flags;
    b_flags_next.ovf = (RW'(a_nm) << FRAC_BITS) >= (RW'(a_dm) << QW);
  end

  always_ff @(posedge clk) begin
    b_flags     <= b_flags_next;
    b_rem       <= RW'(a_nm) << FRAC_BITS;
    b_dm        <= a_dm;
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int BIT = QW - 1 - k;
    logic [RW-1:0]        rem_in;
    logic [AW-1:0]        dm_in;
    logic [QW-1:0]        q_in;
    ptpd_pkg::div_flags_t flags_in;
    logic [RW-1:0]        sub;
    logic                 ge;

    if (k == 0) begin : g_first
      assign rem_in   = b_rem;
      assign dm_in    = b_dm;
      assign q_in     = '0;
      assign flags_in = b_flags;
    end else begin : g_next
      assign rem_in   = s_rem[k-1];
      assign dm_in    = s_dm[k-1];
      assign q_in     = s_q[k-1];
      assign flags_in = s_flags[k-1];
    end

    assign sub = RW'(dm_in) << BIT;
    assign ge  = rem_in >= sub;

    always_ff @(posedge clk) begin
      s_rem[k]      <= ge ? rem_in - sub : rem_in;
      s_dm[k]       <= dm_in;
      s_q[k]        <= q_in | (QW'(ge) << BIT);
      s_flags[k]    <= flags_in;
    end
  end

  ptpd_pkg::div_flags_t f_last;
  logic [QW-1:0]        q_last;
  ptpd_pkg::lane_out_t  res_next;

  assign f_last = s_flags[QW-1];
  assign q_last = s_q[QW-1];

  always_comb begin
    res_next.fault = 1'b0;
    res_next.value = '0;
    if (f_last.dzero) begin
      res_next.fault = 1'b1;
      if (f_last.nzero) begin
        res_next.value = '0;
      end else begin
        res_next.value = f_last.nneg ? ptpd_pkg::SAT_MIN : ptpd_pkg::SAT_MAX;
      end
    end else if (f_last.nneg ^ f_last.dneg) begin
      if (!f_last.ovf && q_last <= QW'(ptpd_pkg::SAT_MIN)) begin
        res_next.value = ptpd_pkg::DATA_W'(QW'(0) - q_last);
      end else begin
        res_next.value = ptpd_pkg::SAT_MIN;
        res_next.fault = 1'b1;
      end
    end else begin
      if (!f_last.ovf && q_last <= QW'(ptpd_pkg::SAT_MAX)) begin
        res_next.value = q_last[ptpd_pkg::DATA_W-1:0];
      end else begin
        res_next.value = ptpd_pkg::SAT_MAX;
        res_next.fault = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

endmodule

@@ rtl/point_transform_perspective_divide_unit.sv @@
// Top level of the homogeneous point transform with perspective divide.
//
// A request is one point (x, y, z) in signed fixed point, taken as the row
// vector (x, y, z, 1) and multiplied by the 4x4 matrix held in eight 64-bit
// APB registers. Each of x, y and z is then divided by w.
// A request is accepted on a clock edge with start high and busy low. busy
// is low at all times except during reset, so a new point can enter on
// every cycle and the block sustains one point per clock.
// Each result appears on result for exactly one cycle, marked by done, once its
// request has passed the point register, the multiply and accumulate stages and
// the divider, which resolves one quotient bit per stage over 33 stages.
// Results leave in request order; the receiver cannot stall them.
// Reset clears the in-flight requests and loads the identity matrix.
// The user must write the matrix only while no request is in flight; the block does not enforce this.
`include "assert_macros.svh"

module point_transform_perspective_divide_unit #(
  parameter int FRAC_BITS = ptpd_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  ptpd_pkg::point_t              point,
  output logic                          done,
  output ptpd_pkg::result_t             result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ptpd_pkg::ADDR_W-1:0]   paddr,
  input  logic [ptpd_pkg::REG_W-1:0]    pwdata,
  output logic [ptpd_pkg::REG_W-1:0]    prdata,
  output logic                          pready
);

  ptpd_pkg::matrix_t                       mat;
  ptpd_pkg::point_t                        pt_q;
  logic [ptpd_pkg::PIPE_LAT-1:0]           valid;
  logic [3:0][ptpd_pkg::ACC_W-1:0]         acc;
  ptpd_pkg::lane_out_t                     lane [3];

  assign busy   = rst;
  assign pready = 1'b1;

  ptpd_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .mat     (mat)
  );

  always_ff @(posedge clk) begin
    pt_q <= point;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[ptpd_pkg::PIPE_LAT-2:0], start && !busy};
    end
  end

  ptpd_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk (clk),
    .pt  (pt_q),
    .mat (mat),
    .acc (acc)
  );

  for (genvar c = 0; c < 3; c++) begin : g_lane
    ptpd_div_lane #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk (clk),
      .num (acc[c]),
      .den (acc[3]),
      .res (lane[c])
    );
  end

  assign done                = valid[ptpd_pkg::PIPE_LAT-1];
  assign result.out_x        = lane[0].value;
  assign result.out_y        = lane[1].value;
  assign result.out_z        = lane[2].value;
  assign result.divide_fault = lane[0].fault | lane[1].fault | lane[2].fault;

  `ASSERT_DELAYED(a_req_to_done, clk, rst, start && !busy, done, ptpd_pkg::PIPE_LAT)
  `ASSERT_IMPLIES(a_done_has_req, clk, rst, done, $past(start && !busy, ptpd_pkg::PIPE_LAT))

endmodule

@@ bench/testbench.sv @@
// Testbench for the point transform with perspective divide: predicted results checked per request.
`timescale 1ns / 1ps

module testbench;

  localparam int LATENCY = ptpd_pkg::PIPE_LAT;
  localparam int FB      = ptpd_pkg::FRAC_BITS_DEF;

  logic                            clk;
  logic                            rst;
  logic                            start;
  logic                            busy;
  ptpd_pkg::point_t                point;
  logic                            done;
  ptpd_pkg::result_t               result;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [ptpd_pkg::ADDR_W-1:0]     paddr;
  logic [ptpd_pkg::REG_W-1:0]      pwdata;
  logic [ptpd_pkg::REG_W-1:0]      prdata;
  logic                            pready;

  point_transform_perspective_divide_unit DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .point(point),
    .done(done), .result(result), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  logic [ptpd_pkg::REG_W-1:0] matrix_regs [ptpd_pkg::NUM_REGS];
  ptpd_pkg::result_t          pending_results [$];
  int                         mismatch_count;
  int                         result_count;
  int                         fault_count;
  int                         request_count;
  bit                         gaps_enabled;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("testbench failed");
    $finish;
  end

  function automatic logic signed [31:0] matrix_elem(int r, int c);
    logic [63:0] v;
    v = matrix_regs[r * 2 + c / 2];
    return (c % 2) ? v[63:32] : v[31:0];
  endfunction

  function automatic logic signed [31:0] divide_lane(logic signed [127:0] num,
                                                     logic signed [127:0] den,
                                                     ref bit fault);
    logic [127:0] nm;
    logic [127:0] dm;
    logic [127:0] q;
    bit           neg;
    if (den == 0) begin
      fault = 1;
      if (num == 0) return 32'sd0;
      return num < 0 ? ptpd_pkg::SAT_MIN : ptpd_pkg::SAT_MAX;
    end
    neg = (num < 0) != (den < 0);
    nm  = num < 0 ? -num : num;
    dm  = den < 0 ? -den : den;
    q   = (nm << FB) / dm;
    if (neg) begin
      if (q <= 128'h8000_0000) return -q[31:0];
      fault = 1;
      return ptpd_pkg::SAT_MIN;
    end
    if (q <= 128'h7FFF_FFFF) return q[31:0];
    fault = 1;
    return ptpd_pkg::SAT_MAX;
  endfunction

  function automatic ptpd_pkg::result_t project_point(ptpd_pkg::point_t p);
    logic signed [127:0] coord [4];
    logic signed [127:0] acc [4];
    ptpd_pkg::result_t   r;
    bit                  fault;
    coord[0] = p.point_x;
    coord[1] = p.point_y;
    coord[2] = p.point_z;
    coord[3] = 128'sd1 <<< FB;
    for (int c = 0; c < 4; c++) begin
      acc[c] = 0;
      for (int k = 0; k < 4; k++) begin
        acc[c] += coord[k] * 128'(matrix_elem(k, c));
      end
    end
    fault   = 0;
    r.out_x = divide_lane(acc[0], acc[3], fault);
    r.out_y = divide_lane(acc[1], acc[3], fault);
    r.out_z = divide_lane(acc[2], acc[3], fault);
    r.divide_fault = fault;
    return r;
  endfunction

  task automatic idle_gap();
    if (gaps_enabled && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  task automatic send_point(ptpd_pkg::point_t p);
    start <= 1'b1;
    point <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(project_point(p));
    request_count++;
    idle_gap();
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(int idx, logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ptpd_pkg::ADDR_W'(idx * 8);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx < ptpd_pkg::NUM_REGS) matrix_regs[idx] = value;
  endtask

  task automatic load_matrix(logic [63:0] regs [ptpd_pkg::NUM_REGS]);
    drain();
    for (int i = 0; i < ptpd_pkg::NUM_REGS; i++) write_reg(i, regs[i]);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] random_word();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($signed($urandom_range(0, 8)) - 4) <<< FB;
      3: return $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic ptpd_pkg::point_t random_point();
    ptpd_pkg::point_t p;
    p.point_x = random_word();
    p.point_y = random_word();
    p.point_z = random_word();
    return p;
  endfunction

  task automatic test_identity();
    logic [31:0] edges [6] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h1,
                               32'hFFFF_FFFF, 32'h0001_0000};
    for (int i = 0; i < 6; i++) begin
      send_point('{edges[i], edges[(i + 1) % 6], edges[(i + 2) % 6]});
    end
  endtask

  task automatic test_special_cases();
    logic [63:0] regs [ptpd_pkg::NUM_REGS];
    // The w column is zero except for z, so z = 0 gives a zero divisor.
    regs = '{64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
             64'h0, 64'h0001_0000_0001_0000, 64'h0, 64'h0};
    load_matrix(regs);
    send_point('{32'h0001_0000, 32'hFFFF_0000, 32'h0});
    send_point('{32'h0, 32'h0, 32'h0});
    send_point('{32'h7FFF_FFFF, 32'h8000_0000, 32'h0});
    send_point('{32'h7FFF_FFFF, 32'h8000_0000, 32'h1});
    send_point('{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF});
    send_point('{32'h0, 32'h0, 32'h8000_0000});
    regs = '{64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_8000_0000,
             64'h7FFF_FFFF_7FFF_FFFF, 64'h8000_0000_7FFF_FFFF,
             64'h7FFF_FFFF_8000_0000, 64'h0000_0001_FFFF_FFFF,
             64'h8000_0000_8000_0000, 64'h7FFF_FFFF_7FFF_FFFF};
    load_matrix(regs);
    send_point('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    send_point('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    send_point('{32'h0, 32'h0, 32'h0});
    send_point('{32'h1, 32'hFFFF_FFFF, 32'h8000_0000});
  endtask

  task automatic test_random(int phases, int per_phase);
    logic [63:0] regs [ptpd_pkg::NUM_REGS];
    for (int ph = 0; ph < phases; ph++) begin
      for (int i = 0; i < ptpd_pkg::NUM_REGS; i++) begin
        case ($urandom_range(0, 3))
          0: regs[i] = {random_word(), random_word()};
          1: regs[i] = {$urandom, $urandom};
          2: regs[i] = {32'($urandom_range(0, 4)) << FB, 32'($urandom_range(0, 4)) << FB};
          default: regs[i] = {32'($signed($urandom_range(0, 32'hFFFF)) - 32'h8000),
                              32'($signed($urandom_range(0, 32'hFFFF)) - 32'h8000)};
        endcase
      end
      load_matrix(regs);
      for (int n = 0; n < per_phase; n++) send_point(random_point());
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      ptpd_pkg::result_t exp;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result %h", result);
      end else begin
        exp = pending_results.pop_front();
        result_count++;
        if (result.divide_fault) fault_count++;
        if (result.out_x !== exp.out_x || result.out_y !== exp.out_y ||
            result.out_z !== exp.out_z || result.divide_fault !== exp.divide_fault) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: expected %h %h %h %b, got %h %h %h %b",
                     exp.out_x, exp.out_y, exp.out_z, exp.divide_fault,
                     result.out_x, result.out_y, result.out_z, result.divide_fault);
          end
        end
      end
    end
  end

  initial begin
    rst     = 1'b1;
    start   = 1'b0;
    point   = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    gaps_enabled = 1'b1;
    mismatch_count = 0;
    result_count = 0;
    fault_count = 0;
    request_count = 0;
    for (int i = 0; i < ptpd_pkg::NUM_REGS; i++) matrix_regs[i] = ptpd_pkg::MAT_RESET[i];
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_identity();
    test_special_cases();
    test_random(12, 140);
    gaps_enabled = 1'b0;
    test_random(2, 120);
    drain();
    if (pending_results.size() != 0) mismatch_count++;
    $display("Sent %0d points over 17 matrix settings; %0d results, %0d with a fault.",
             request_count, result_count, fault_count);
    if (mismatch_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+rtl
rtl/ptpd_pkg.sv
rtl/ptpd_cfg_regs.sv
rtl/ptpd_mac.sv
rtl/ptpd_div_lane.sv
rtl/point_transform_perspective_divide_unit.sv
bench/testbench.sv
